### src/tmccp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmccp_pkg;

  // Map geometry (power-of-two row and column counts)
  localparam int MAP_COLUMNS = 32;
  localparam int MAP_ROWS    = 32;
  localparam int TILE_SHIFT  = 3;
  localparam int MAP_SIZE    = MAP_ROWS * MAP_COLUMNS;
  localparam int COL_BITS    = $clog2(MAP_COLUMNS);
  localparam int ROW_BITS    = $clog2(MAP_ROWS);
  localparam int ADDR_BITS   = ROW_BITS + COL_BITS;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int MADDR_W  = 10;
  localparam int BYTE_W   = 8;
  localparam int TIDX_W   = 10;
  localparam int HROW_W   = 5;
  localparam int HCOL_W   = 5;
  localparam int CFG_IDX_W = 2;

  // Signed width of an edge position after offsets and scroll
  localparam int POS_W = BYTE_W + 3;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BULLET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SOLID  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PICKUP = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0] TOP_RESET       = 8'd16;
  localparam logic [BYTE_W-1:0] LEFT_RESET      = 8'd8;
  localparam logic [BYTE_W-1:0] THRESHOLD_RESET = 8'd255;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [MADDR_W-1:0] map_address;
    logic [BYTE_W-1:0]  map_value;
    logic [BYTE_W-1:0]  box_x;
    logic [BYTE_W-1:0]  box_y;
    logic [BYTE_W-1:0]  box_width;
    logic [BYTE_W-1:0]  box_height;
    logic [BYTE_W-1:0]  scroll_x;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [TIDX_W-1:0] tile_index;
    logic [HROW_W-1:0] hit_row;
    logic [HCOL_W-1:0] hit_col;
  } out_item_t;

  // Map write port
  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [BYTE_W-1:0]    data;
  } map_wr_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_TEST
  } state_t;

endpackage

`default_nettype wire

### src/tmccp_map_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tmccp_map_ram import tmccp_pkg::*; (
  input  wire logic                 clk,
  input  wire map_wr_t              wr,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [BYTE_W-1:0]    rd_data
);

  logic [BYTE_W-1:0] mem [MAP_SIZE];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### src/tile_map_corner_collision_probe.sv
// Tile map corner collision probe.
// Input channel in_valid/in_ready/in_data carries write items and probe items;
// result channel out_valid/out_ready/out_data carries one result per probe.
// Write items give no result. Registers are set through cfg_we/cfg_index/
// cfg_data, between items while no probe is in flight: a rule for the user
// that the block does not enforce. After reset the map is cleared by a pass
// over all 1024 entries, one entry a cycle; in_ready stays low for the pass.
// A write item is taken while in_ready is high; the sequencer stays idle.
// A probe reads the map once per corner through the single read port of the
// map memory: a read state (address), then a test state (registered data and
// qualify compare). Bullet probes read up to two corners, solid and pickup
// probes up to four, stopping at the first hit. The result is registered
// in the same cycle that the sequencer returns to idle, so in_ready and
// out_valid rise together.
// in_ready is low while a probe is in flight.
// A result waits in the output register until taken; if the receiver stalls
// and a second probe finishes, that probe holds its last compare until the
// output register frees.
`timescale 1ns / 1ps
`default_nettype none

module tile_map_corner_collision_probe import tmccp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  state_t               state_r, state_nxt;
  logic [ADDR_BITS-1:0] clear_cnt_r, clear_cnt_nxt;
  logic [1:0]           corner_r, corner_nxt;
  logic [KIND_W-1:0]    kind_r;
  logic [ROW_BITS-1:0]  row_top_r, row_bot_r;
  logic [COL_BITS-1:0]  col_left_r, col_right_r;
  logic [BYTE_W-1:0]    top_r, left_r, thr_r;
  out_item_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  map_wr_t              map_wr;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [BYTE_W-1:0]    rd_data;

  logic                 accept;
  logic                 out_free;
  logic                 last_corner;
  logic                 below_thr;
  logic                 qualify;
  logic [ROW_BITS-1:0]  cur_row;
  logic [COL_BITS-1:0]  cur_col;

  logic signed [POS_W-1:0] pos_ty, pos_by, pos_lx, pos_rx;
  logic signed [POS_W-1:0] sh_ty, sh_by, sh_lx, sh_rx;

  tmccp_map_ram u_map (
    .clk     (clk),
    .wr      (map_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= TOP_RESET;
      left_r <= LEFT_RESET;
      thr_r  <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOP:       top_r  <= cfg_data;
        CFG_LEFT:      left_r <= cfg_data;
        CFG_THRESHOLD: thr_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Edge positions; arithmetic shift gives the floored tile
  always_comb begin
    pos_ty = signed'(POS_W'(in_data.box_y)) - signed'(POS_W'(top_r));
    pos_by = signed'(POS_W'(in_data.box_y)) + signed'(POS_W'(in_data.box_height))
           - signed'(POS_W'(top_r));
    pos_lx = signed'(POS_W'(in_data.box_x)) + signed'(POS_W'(in_data.scroll_x))
           - signed'(POS_W'(left_r));
    pos_rx = signed'(POS_W'(in_data.box_x)) + signed'(POS_W'(in_data.box_width))
           + signed'(POS_W'(in_data.scroll_x)) - signed'(POS_W'(left_r));
    sh_ty  = pos_ty >>> TILE_SHIFT;
    sh_by  = pos_by >>> TILE_SHIFT;
    sh_lx  = pos_lx >>> TILE_SHIFT;
    sh_rx  = pos_rx >>> TILE_SHIFT;
  end

  // Capture the probe's rows and columns
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_data.kind;
      row_top_r   <= sh_ty[ROW_BITS-1:0];
      row_bot_r   <= sh_by[ROW_BITS-1:0];
      col_left_r  <= sh_lx[COL_BITS-1:0];
      col_right_r <= sh_rx[COL_BITS-1:0];
    end
  end

  // Corner order: top-right, bottom-right, top-left, bottom-left
  assign cur_row     = corner_r[0] ? row_bot_r : row_top_r;
  assign cur_col     = corner_r[1] ? col_left_r : col_right_r;
  assign rd_addr     = {cur_row, cur_col};
  assign last_corner = (kind_r == KIND_BULLET) ? (corner_r == 2'd1) : (corner_r == 2'd3);

  // Shared compare against the threshold
  assign below_thr = rd_data < thr_r;

  always_comb begin
    unique case (kind_r)
      KIND_BULLET: qualify = (rd_data != '0) && below_thr;
      KIND_SOLID:  qualify = (rd_data != '0);
      KIND_PICKUP: qualify = !below_thr;
      default:     qualify = 1'b0;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clear_cnt_nxt = clear_cnt_r;
    corner_nxt    = corner_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    map_wr.en     = 1'b0;
    map_wr.addr   = ADDR_BITS'(in_data.map_address);
    map_wr.data   = in_data.map_value;
    unique case (state_r)
      ST_CLEAR: begin
        map_wr.en     = 1'b1;
        map_wr.addr   = clear_cnt_r;
        map_wr.data   = '0;
        clear_cnt_nxt = clear_cnt_r + 1'b1;
        if (clear_cnt_r == ADDR_BITS'(MAP_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        corner_nxt = 2'd0;
        if (accept) begin
          if (in_data.kind == KIND_WRITE) begin
            map_wr.en = (32'(in_data.map_address) < MAP_SIZE);
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (qualify || last_corner) begin
          // hold the compare until the output register frees
          if (out_free) begin
            out_valid_nxt      = 1'b1;
            out_nxt.hit        = qualify;
            out_nxt.tile_index = qualify ? TIDX_W'(rd_addr) : '0;
            out_nxt.hit_row    = qualify ? HROW_W'(cur_row) : '0;
            out_nxt.hit_col    = qualify ? HCOL_W'(cur_col) : '0;
            state_nxt          = ST_IDLE;
          end
        end else begin
          corner_nxt = corner_r + 1'b1;
          state_nxt  = ST_READ;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clear_cnt_r <= '0;
      corner_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clear_cnt_r <= clear_cnt_nxt;
      corner_r    <= corner_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // No item is taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("item accepted during map clear");

  // A miss reports all-zero location fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |->
      (out_data.tile_index == '0 && out_data.hit_row == '0 && out_data.hit_col == '0))
    else $error("miss with nonzero location");

  // A hit index matches its row and column
  a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |->
      (out_data.tile_index ==
       TIDX_W'({ROW_BITS'(out_data.hit_row), COL_BITS'(out_data.hit_col)})))
    else $error("hit index does not match row and column");

  // Bullet probes never go past the bottom-right corner
  a_bullet_corners: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_READ || state_r == ST_TEST) && kind_r == KIND_BULLET) |->
      (corner_r == 2'd0 || corner_r == 2'd1))
    else $error("bullet probe read a left corner");

  // A new probe starts at the first corner
  a_start_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.kind != KIND_WRITE) |=> (state_r == ST_READ && corner_r == 2'd0))
    else $error("probe did not start at the top-right corner");

endmodule

`default_nettype wire
